FILE: rtl/core/oas_pkg.sv
// ----------------------------------------------------------------------------
// oas_pkg
// Types and sizes shared by the ordered array sequence cells, decoder and top.
// ----------------------------------------------------------------------------
package oas_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the request and response words.
  localparam int OPC_W  = 3;
  localparam int POS_FW = 7;
  localparam int VAL_FW = 32;
  localparam int CNT_FW = 7;

  // Cell index and internal count widths.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_FW) ? CNT_W : POS_FW;

  // The last code has no meaning and is ignored by the store.
  typedef enum logic [OPC_W-1:0] {
    OP_READ    = 3'd0,
    OP_INS_FRT = 3'd1,
    OP_INS_REA = 3'd2,
    OP_INS_POS = 3'd3,
    OP_DEL_FRT = 3'd4,
    OP_DEL_REA = 3'd5,
    OP_DEL_POS = 3'd6,
    OP_RSVD    = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [POS_FW-1:0] position;
    logic [VAL_FW-1:0] value;
  } oas_req_t;

  typedef struct packed {
    logic [VAL_FW-1:0] read_value;
    logic [CNT_FW-1:0] count;
    status_t           status;
  } oas_rsp_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_W-1:0]      at;
    logic [DATA_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]      rd_idx;
  } cell_ctl_t;

  // Per-operation outcome from the decoder.
  typedef struct packed {
    logic             rd_en;
    status_t          status;
    logic [CNT_W-1:0] count_next;
  } oas_dec_t;

endpackage

FILE: rtl/core/ordered_array_sequence.sv
// ----------------------------------------------------------------------------
// ordered_array_sequence
// Fixed-capacity ordered sequence with indexed read, insert and delete.
// ----------------------------------------------------------------------------
// Usage: a request word (opcode, position, value) enters on the req channel
// and exactly one response word (read value, count after the operation,
// status) leaves on the rsp channel. Both channels use valid and stall; a
// word moves on a rising edge where valid is high and stall is low.
// The store is a chain of CAPACITY cells, one entry each. Every cell compares
// its own index with the operation's position and, in the same cycle, either
// keeps its word, takes its front neighbor's word (insert), takes its rear
// neighbor's word (delete) or loads the new value.
// The response is registered on the edge that accepts the request. Throughput
// is one request per cycle, as long as the receiver does not stall.
// While the receiver stalls a pending response, req_stall is raised and the
// response word holds. Reset clears the count and the response valid; cell
// contents are not cleared and are only read below the count.
// Failed operations (full, empty, out of range) leave the store unchanged.
// ----------------------------------------------------------------------------
module ordered_array_sequence
  import oas_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  oas_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output oas_rsp_t rsp
);

  logic             accept;
  logic [CNT_W-1:0] count;
  cell_ctl_t        ctl;
  cell_ctl_t        ctl_gated;
  oas_dec_t         dec;

  logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;

  // A new request is taken unless a response is waiting on a stalled receiver.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  oas_dec u_dec (
    .req   (req),
    .count (count),
    .ctl   (ctl),
    .dec   (dec)
  );

  // The cells only shift on an accepted request.
  always_comb begin
    ctl_gated     = ctl;
    ctl_gated.ins = ctl.ins && accept;
    ctl_gated.del = ctl.del && accept;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_word[i+1];
    end

    oas_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(i)),
      .ctl     (ctl_gated),
      .left    (left),
      .right   (right),
      .word    (cell_word[i]),
      .rd_word (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero read word, so an OR collects it.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else if (accept) begin
      count     <= dec.count_next;
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value <= dec.rd_en ? VAL_FW'(rd_data) : '0;
      rsp.count      <= CNT_FW'(dec.count_next);
      rsp.status     <= dec.status;
    end
  end

endmodule

FILE: rtl/core/oas_cell.sv
// ----------------------------------------------------------------------------
// oas_cell
// One entry of the sequence; shifts toward the rear on insert and toward the
// front on delete, taking data from its neighbors.
// ----------------------------------------------------------------------------
module oas_cell
  import oas_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      idx,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] rd_word
);

  logic [DATA_WIDTH-1:0] word_next;

  always_comb begin
    word_next = word;
    if (ctl.ins) begin
      if (idx > ctl.at) begin
        word_next = left;
      end else if (idx == ctl.at) begin
        word_next = ctl.wdata;
      end
    end else if (ctl.del && (idx >= ctl.at)) begin
      word_next = right;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign rd_word = (idx == ctl.rd_idx) ? word : '0;

endmodule

FILE: rtl/core/oas_dec.sv
// ----------------------------------------------------------------------------
// oas_dec
// Decodes one request against the current count: range checks, status, the
// new count and the shift control for the cell chain.
// ----------------------------------------------------------------------------
module oas_dec
  import oas_pkg::*;
(
  input  oas_req_t         req,
  input  logic [CNT_W-1:0] count,
  output cell_ctl_t        ctl,
  output oas_dec_t         dec
);

  logic [CMP_W-1:0] cnt_c;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] at_c;

  assign cnt_c = CMP_W'(count);
  assign pos_c = CMP_W'(req.position);

  always_comb begin
    at_c           = '0;
    ctl.ins        = 1'b0;
    ctl.del        = 1'b0;
    ctl.wdata      = req.value[DATA_WIDTH-1:0];
    ctl.rd_idx     = req.position[IDX_W-1:0];
    dec.rd_en      = 1'b0;
    dec.status     = ST_OK;
    dec.count_next = count;
    unique case (req.opcode) inside
      OP_READ: begin
        if (pos_c < cnt_c) begin
          dec.rd_en = 1'b1;
        end else begin
          dec.status = ST_RANGE;
        end
      end
      OP_INS_FRT, OP_INS_REA, OP_INS_POS: begin
        if (cnt_c >= CMP_W'(CAPACITY)) begin
          dec.status = ST_FULL;
        end else begin
          if (req.opcode == OP_INS_FRT) begin
            at_c = '0;
          end else if (req.opcode == OP_INS_REA) begin
            at_c = cnt_c;
          end else begin
            at_c = pos_c;
          end
          if (at_c > cnt_c) begin
            dec.status = ST_RANGE;
          end else begin
            ctl.ins        = 1'b1;
            dec.count_next = count + CNT_W'(1);
          end
        end
      end
      OP_DEL_FRT, OP_DEL_REA, OP_DEL_POS: begin
        if (count == '0) begin
          dec.status = ST_EMPTY;
        end else begin
          if (req.opcode == OP_DEL_FRT) begin
            at_c = '0;
          end else if (req.opcode == OP_DEL_REA) begin
            at_c = cnt_c - CMP_W'(1);
          end else begin
            at_c = pos_c;
          end
          if (at_c >= cnt_c) begin
            dec.status = ST_RANGE;
          end else begin
            ctl.del        = 1'b1;
            dec.count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    ctl.at = at_c[IDX_W-1:0];
  end

endmodule

FILE: rtl/core/oas_checker.sv
// ----------------------------------------------------------------------------
// oas_checker
// Port-level checks on the request and response channels of the ordered array sequence.
// ----------------------------------------------------------------------------
module oas_checker
  import oas_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input oas_rsp_t rsp
);

  // A stalled response word holds until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // A full report means the store really is at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.count == CNT_FW'(CAPACITY))
    else $error("full status with count below capacity");

  // An empty report means the count is zero.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |-> rsp.count == '0)
    else $error("empty status with nonzero count");

  // Failed operations never return data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.read_value == '0)
    else $error("read value on failed operation");

  // An accepted request yields a response in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("no response after accepted request");

endmodule

bind ordered_array_sequence oas_checker u_oas_checker (.*);

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered array sequence store. A shadow copy of
// the sequence predicts one response word for every accepted request word,
// and the checker compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oas_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int SEG_ITEMS   = 100;
  localparam int SEG_COUNT   = 7;
  localparam int SHOW_LIMIT  = 40;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  oas_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  oas_rsp_t rsp;

  ordered_array_sequence DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the sequence: entries 0 .. shadow_len-1 are live.
  logic [DATA_WIDTH-1:0] shadow_mem [CAPACITY];
  int                    shadow_len = 0;

  // Responses predicted for accepted requests, oldest first.
  oas_rsp_t due_rsp [$];

  int errors   = 0;
  int rsp_seen = 0;

  // Sender pacing: words go out in bursts separated by idle gaps.
  int burst_left = 0;
  int gap_max    = 0;

  // Receiver pattern: runs of stall or no stall, plus an optional long hold.
  int stall_pct = 0;
  int hold_left = 0;
  int run_left  = 0;

  oas_rsp_t want;

  // Apply one request to the shadow sequence and return the response that
  // the store must give for it. Failed operations leave the shadow alone.
  function automatic oas_rsp_t seq_apply(oas_req_t r);
    oas_rsp_t o;
    int       pos;
    int       at;
    int       i;
    o        = '0;
    o.status = ST_OK;
    pos      = int'(r.position);
    case (r.opcode) inside
      OP_READ: begin
        if (pos < shadow_len) o.read_value = VAL_FW'(shadow_mem[pos]);
        else o.status = ST_RANGE;
      end
      OP_INS_FRT, OP_INS_REA, OP_INS_POS: begin
        // The full check wins over the position check.
        if (shadow_len >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          at = (r.opcode == OP_INS_FRT) ? 0 :
               (r.opcode == OP_INS_REA) ? shadow_len : pos;
          if (at > shadow_len) begin
            o.status = ST_RANGE;
          end else begin
            for (i = shadow_len; i > at; i--) shadow_mem[i] = shadow_mem[i-1];
            shadow_mem[at] = r.value[DATA_WIDTH-1:0];
            shadow_len++;
          end
        end
      end
      OP_DEL_FRT, OP_DEL_REA, OP_DEL_POS: begin
        if (shadow_len == 0) begin
          o.status = ST_EMPTY;
        end else begin
          at = (r.opcode == OP_DEL_FRT) ? 0 :
               (r.opcode == OP_DEL_REA) ? shadow_len - 1 : pos;
          if (at >= shadow_len) begin
            o.status = ST_RANGE;
          end else begin
            for (i = at; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
            shadow_len--;
          end
        end
      end
      default: ;  // The unused opcode changes nothing.
    endcase
    o.count = CNT_FW'(shadow_len);
    return o;
  endfunction

  task automatic flag(string what, logic [31:0] got, logic [31:0] exp_val);
    if (errors < SHOW_LIMIT)
      $display("rsp %0d: %s got %0h, predicted %0h", rsp_seen, what, got, exp_val);
    errors++;
  endtask

  // Checker and predictor share one process so that the order of pops and
  // pushes is fixed. Signals are read at the edge, before any of this edge's
  // updates land, so each handshake is seen exactly as the store saw it.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          flag("response with nothing outstanding, count", 32'(rsp.count), '0);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.read_value !== want.read_value)
            flag("read_value", rsp.read_value, want.read_value);
          if (rsp.count !== want.count)
            flag("count", 32'(rsp.count), 32'(want.count));
          if (rsp.status !== want.status)
            flag("status", 32'(rsp.status), 32'(want.status));
        end
        rsp_seen++;
      end
      if (req_valid && !req_stall) due_rsp.push_back(seq_apply(req));
    end
  end

  // Receiver. A long hold, once requested, overrides the random pattern and
  // is counted down here one cycle at a time.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        run_left  = $urandom_range(0, 7);
      end
    end
  end

  function automatic oas_req_t make_req(opcode_t op, int pos, logic [31:0] v);
    oas_req_t w;
    w.opcode   = op;
    w.position = POS_FW'(pos);
    w.value    = v;
    return w;
  endfunction

  function automatic logic [31:0] rand_value();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return 32'h0000_0000;
    if (k == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // Random request word. Positions lean toward small indexes so that indexed
  // operations land inside the live range often, with the whole 7-bit field
  // still covered now and then.
  function automatic oas_req_t rand_req(int ins_pct, int del_pct);
    oas_req_t w;
    int       r;
    int       k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 2);
    if (r < ins_pct)
      w.opcode = (k == 0) ? OP_INS_FRT : (k == 1) ? OP_INS_REA : OP_INS_POS;
    else if (r < ins_pct + del_pct)
      w.opcode = (k == 0) ? OP_DEL_FRT : (k == 1) ? OP_DEL_REA : OP_DEL_POS;
    else if (r < 97)
      w.opcode = OP_READ;
    else
      w.opcode = OP_RSVD;
    k = $urandom_range(0, 9);
    if (k < 5) w.position = POS_FW'($urandom_range(0, 15));
    else if (k < 8) w.position = POS_FW'($urandom_range(0, CAPACITY));
    else w.position = POS_FW'($urandom_range(0, 127));
    w.value = rand_value();
    return w;
  endfunction

  // Offer one word and hold it until the store takes it. Valid stays high on
  // return, so back-to-back words never toggle it within one time step.
  task automatic put_word(oas_req_t w);
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic rest(int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      rest((gap_max == 0) ? 0 : $urandom_range(0, gap_max));
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Stop sending and wait until every predicted response has come back.
  task automatic wait_idle();
    int guard;
    guard = 0;
    req_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (due_rsp.size() != 0 && guard < 5000);
  endtask

  // Every error path on an empty store, then the first insert.
  task automatic test_empty_store();
    put_word(make_req(OP_READ, 0, 32'h0));
    put_word(make_req(OP_READ, 127, 32'hFFFF_FFFF));
    put_word(make_req(OP_DEL_FRT, 0, 32'h0));
    put_word(make_req(OP_DEL_REA, 0, 32'h0));
    put_word(make_req(OP_DEL_POS, 0, 32'h0));
    put_word(make_req(OP_RSVD, 127, 32'hFFFF_FFFF));
    put_word(make_req(OP_INS_POS, 1, 32'h1234_5678));
    put_word(make_req(OP_INS_POS, 127, 32'h1234_5678));
    put_word(make_req(OP_INS_POS, 0, 32'h8000_0001));
    wait_idle();
  endtask

  // One of each operation on a short sequence, with positions past the count:
  // inserts, reads and deletes there are out of range.
  task automatic test_basic_ops();
    put_word(make_req(OP_INS_FRT, 0, 32'hFFFF_FFFF));
    put_word(make_req(OP_INS_REA, 0, 32'h0000_0000));
    put_word(make_req(OP_INS_POS, 1, 32'hA5A5_A5A5));
    put_word(make_req(OP_INS_POS, 4, 32'h5A5A_5A5A));
    put_word(make_req(OP_READ, 0, 32'h0));
    put_word(make_req(OP_READ, 2, 32'h0));
    put_word(make_req(OP_READ, 4, 32'h0));
    put_word(make_req(OP_READ, 5, 32'h0));
    put_word(make_req(OP_DEL_POS, 5, 32'h0));
    put_word(make_req(OP_DEL_POS, 127, 32'h0));
    put_word(make_req(OP_DEL_POS, 2, 32'h0));
    put_word(make_req(OP_RSVD, 1, 32'h0));
    put_word(make_req(OP_DEL_FRT, 0, 32'h0));
    put_word(make_req(OP_DEL_REA, 0, 32'h0));
    put_word(make_req(OP_READ, 1, 32'h0));
    put_word(make_req(OP_DEL_POS, 0, 32'h0));
    put_word(make_req(OP_DEL_POS, 0, 32'h0));
    wait_idle();
  endtask

  // Fill to capacity with random inserts, probe every insert form when full
  // (including a bad position, where full must win), then empty it again.
  task automatic test_fill_and_drain();
    int n;
    int k;
    stall_pct = 30;
    gap_max   = 3;
    for (n = 0; n < CAPACITY; n++) begin
      pace();
      k = $urandom_range(0, 2);
      if (k == 0) put_word(make_req(OP_INS_FRT, $urandom_range(0, 127), rand_value()));
      else if (k == 1) put_word(make_req(OP_INS_REA, $urandom_range(0, 127), rand_value()));
      else put_word(make_req(OP_INS_POS, $urandom_range(0, n), rand_value()));
    end
    put_word(make_req(OP_INS_FRT, 0, 32'hDEAD_BEEF));
    put_word(make_req(OP_INS_REA, 0, 32'hDEAD_BEEF));
    put_word(make_req(OP_INS_POS, 0, 32'hDEAD_BEEF));
    put_word(make_req(OP_INS_POS, CAPACITY, 32'hDEAD_BEEF));
    put_word(make_req(OP_INS_POS, 127, 32'hDEAD_BEEF));
    put_word(make_req(OP_READ, CAPACITY - 1, 32'h0));
    put_word(make_req(OP_READ, CAPACITY, 32'h0));
    for (n = CAPACITY; n > 0; n--) begin
      pace();
      put_word(make_req(OP_READ, $urandom_range(0, n - 1), 32'h0));
      k = $urandom_range(0, 2);
      if (k == 0) put_word(make_req(OP_DEL_FRT, 0, 32'h0));
      else if (k == 1) put_word(make_req(OP_DEL_REA, 0, 32'h0));
      else put_word(make_req(OP_DEL_POS, $urandom_range(0, n - 1), 32'h0));
    end
    put_word(make_req(OP_DEL_FRT, 0, 32'h0));
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words, so the store must raise req_stall and keep its
  // response steady until the hold ends.
  task automatic test_backpressure();
    int n;
    stall_pct = 0;
    gap_max   = 0;
    hold_left = HOLD_CYCLES;
    for (n = 0; n < 80; n++) put_word(rand_req(50, 25));
    wait_idle();
  endtask

  // Long random run in segments. Each segment picks a growth profile, a
  // receiver stall rate and a sender gap size; some segments run flat out.
  task automatic test_random_mix();
    int seg;
    int n;
    int prof;
    int ins_pct;
    int del_pct;
    for (seg = 0; seg < SEG_COUNT; seg++) begin
      prof = $urandom_range(0, 2);
      ins_pct = (prof == 0) ? 70 : (prof == 1) ? 15 : 35;
      del_pct = (prof == 0) ? 15 : (prof == 1) ? 70 : 35;
      if ($urandom_range(0, 3) == 0) begin
        stall_pct = 0;
        gap_max   = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: stall_pct = 20;
          1: stall_pct = 50;
          default: stall_pct = 80;
        endcase
        gap_max = $urandom_range(1, 6);
      end
      for (n = 0; n < SEG_ITEMS; n++) begin
        pace();
        put_word(rand_req(ins_pct, del_pct));
      end
    end
    stall_pct = 0;
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_basic_ops();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();
    // The idle wait below makes sure nothing stray comes out.
    repeat (8) @(posedge clk);
    if (due_rsp.size() != 0)
      flag("responses never delivered", 32'(due_rsp.size()), '0);
    if (errors == 0) begin
      $display("ordered_array_sequence: match");
    end else begin
      $display("ordered_array_sequence: mismatch");
    end
    $finish;
  end

  // Ends the run as a mismatch if it hangs.
  initial begin
    #400_000;
    $display("ordered_array_sequence: mismatch");
    $finish;
  end

endmodule
